FILE: hw/rtl/lmux_pkg.sv
// Shared types, codes, microcode format and transition table for the LACP mux sequencer.
package lmux_pkg;

  localparam int EvW  = 3;
  localparam int SelW = 2;
  localparam int HopW = 3;

  typedef enum logic [1:0] {
    ST_DETACHED = 2'd0,
    ST_WAITING  = 2'd1,
    ST_ATTACHED = 2'd2,
    ST_COLLDIST = 2'd3
  } port_state_t;

  localparam logic [EvW-1:0] EV_BEGIN      = 3'd0;
  localparam logic [EvW-1:0] EV_SELECTED   = 3'd1;
  localparam logic [EvW-1:0] EV_STANDBY    = 3'd2;
  localparam logic [EvW-1:0] EV_UNSELECTED = 3'd3;
  localparam logic [EvW-1:0] EV_READY      = 3'd4;
  localparam logic [EvW-1:0] EV_SYNC       = 3'd5;

  localparam logic [SelW-1:0] SEL_UNSEL = 2'd0;
  localparam logic [SelW-1:0] SEL_SEL   = 2'd1;
  localparam logic [SelW-1:0] SEL_STBY  = 2'd2;

  // Actor bit positions
  localparam int BitSync = 0;
  localparam int BitColl = 1;
  localparam int BitDist = 2;

  typedef enum logic [1:0] {
    JMP_DET  = 2'd0,
    JMP_WAIT = 2'd1,
    JMP_ATT  = 2'd2,
    JMP_CD   = 2'd3
  } jmp_t;

  typedef struct packed {
    logic [2:0] act_clr;
    logic [2:0] act_set;
    logic       mem_clr;
    logic       mem_set;
    logic       rdy_clr;
    logic       ntt;
    logic       wstart;
    jmp_t       jmp;
  } uop_t;

  typedef struct packed {
    port_state_t pstate;
    logic [2:0]  actor;
    logic        ready_flag;
    logic        member;
    logic        ntt;
    logic        wstart;
  } dp_view_t;

  function automatic port_state_t lmux_next_state(port_state_t st, logic [EvW-1:0] ev);
    port_state_t ns;
    ns = st;
    unique case (st)
      ST_DETACHED: begin
        if (ev == EV_SELECTED || ev == EV_STANDBY) ns = ST_WAITING;
        else ns = ST_DETACHED;
      end
      ST_WAITING: begin
        if (ev == EV_BEGIN || ev == EV_UNSELECTED) ns = ST_DETACHED;
        else if (ev == EV_READY) ns = ST_ATTACHED;
        else ns = ST_WAITING;
      end
      ST_ATTACHED: begin
        if (ev == EV_SELECTED || ev == EV_READY) ns = ST_ATTACHED;
        else if (ev == EV_SYNC) ns = ST_COLLDIST;
        else ns = ST_DETACHED;
      end
      ST_COLLDIST: begin
        if (ev == EV_BEGIN) ns = ST_DETACHED;
        else if (ev == EV_UNSELECTED) ns = ST_ATTACHED;
        else ns = ST_COLLDIST;
      end
      default: ns = st;
    endcase
    return ns;
  endfunction

endpackage

FILE: hw/rtl/lmux_rom.sv
// Microcode ROM: one entry-action control word per mux state.
module lmux_rom import lmux_pkg::*; (
  input  port_state_t st,
  output uop_t        uop
);

  always_comb begin
    uop = '0;
    unique case (st)
      ST_DETACHED: begin
        uop.act_clr = 3'b111;
        uop.mem_clr = 1'b1;
        uop.rdy_clr = 1'b1;
        uop.ntt     = 1'b1;
        uop.jmp     = JMP_DET;
      end
      ST_WAITING: begin
        uop.wstart = 1'b1;
        uop.jmp    = JMP_WAIT;
      end
      ST_ATTACHED: begin
        uop.act_clr = 3'b110;
        uop.act_set = 3'b001;
        uop.mem_clr = 1'b1;
        uop.ntt     = 1'b1;
        uop.jmp     = JMP_ATT;
      end
      ST_COLLDIST: begin
        uop.act_set = 3'b111;
        uop.mem_set = 1'b1;
        uop.ntt     = 1'b1;
        uop.jmp     = JMP_CD;
      end
      default: uop = '0;
    endcase
  end

endmodule

FILE: hw/rtl/lmux_dp.sv
// Datapath: mux state, actor bits, ready and member flags, per-item ntt and wait_start.
module lmux_dp import lmux_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_en,
  input  logic        ready_set,
  input  logic        step_en,
  input  port_state_t ns,
  input  uop_t        uop,
  output dp_view_t    cur,
  output dp_view_t    nxt
);

  dp_view_t view_r;

  always_comb begin
    nxt = view_r;
    if (load_en) begin
      nxt.ready_flag = view_r.ready_flag | ready_set;
      nxt.ntt        = 1'b0;
      nxt.wstart     = 1'b0;
    end else if (step_en) begin
      nxt.pstate = ns;
      nxt.actor  = (view_r.actor & ~uop.act_clr) | uop.act_set;
      if (uop.mem_clr) nxt.member = 1'b0;
      if (uop.mem_set) nxt.member = 1'b1;
      if (uop.rdy_clr) nxt.ready_flag = 1'b0;
      nxt.ntt    = view_r.ntt | uop.ntt;
      nxt.wstart = view_r.wstart | uop.wstart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '{pstate: ST_DETACHED, default: '0};
    end else begin
      view_r <= nxt;
    end
  end

  assign cur = view_r;

endmodule

FILE: hw/rtl/lacp_mux_state_machine_core.sv
// Top level: handshakes, microcode sequencer and result register of the LACP mux machine.
// Each input runs a cascade of transitions (1 to 4 for real inputs; an unknown event code
// makes none). The sequencer steps one transition per cycle but holds the last step until
// the result register is free; a new item is accepted only while the sequencer is idle.
// The result register lets the next item enter while a result waits to be taken.
// Reset (rst_n low, synchronous): detached, actor bits, ready and member flags cleared.
module lacp_mux_state_machine_core import lmux_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [EvW-1:0]       in_event_req,
  input  logic [SelW-1:0]      in_selection,
  input  logic                 in_partner_sync,
  input  logic                 in_ready_set,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_mux_state_out,
  output logic                 out_actor_sync,
  output logic                 out_actor_collecting,
  output logic                 out_actor_distributing,
  output logic                 out_need_to_transmit,
  output logic                 out_bond_member,
  output logic                 out_wait_start
);

  typedef enum logic {S_IDLE, S_RUN} seq_t;

  seq_t             seq_r;
  logic [EvW-1:0]   ev_r;
  logic [SelW-1:0]  sel_r;
  logic             psync_r;
  logic [HopW-1:0]  hop_r;
  logic             out_valid_r;
  dp_view_t         res_r;

  dp_view_t    cur, nxt;
  port_state_t ns;
  uop_t        uop;
  logic        in_xfer, ev_live, has_follow, last, out_free, go;
  logic [EvW-1:0] follow;

  assign in_ready = (seq_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign ev_live  = (ev_r <= EV_SYNC);
  assign ns       = lmux_next_state(cur.pstate, ev_r);

  lmux_rom u_rom (
    .st  (ns),
    .uop (uop)
  );

  always_comb begin
    has_follow = 1'b0;
    follow     = EV_BEGIN;
    unique case (uop.jmp)
      JMP_DET: begin
        if (sel_r == SEL_SEL) begin
          has_follow = 1'b1; follow = EV_SELECTED;
        end else if (sel_r == SEL_STBY) begin
          has_follow = 1'b1; follow = EV_STANDBY;
        end
      end
      JMP_WAIT: begin
        if (sel_r == SEL_SEL && cur.ready_flag) begin
          has_follow = 1'b1; follow = EV_READY;
        end else if (sel_r == SEL_UNSEL) begin
          has_follow = 1'b1; follow = EV_UNSELECTED;
        end
      end
      JMP_ATT: begin
        if (sel_r == SEL_UNSEL || sel_r == SEL_STBY) begin
          has_follow = 1'b1; follow = EV_UNSELECTED;
        end else if (sel_r == SEL_SEL && psync_r) begin
          has_follow = 1'b1; follow = EV_SYNC;
        end
      end
      JMP_CD: begin
        if (sel_r == SEL_UNSEL || sel_r == SEL_STBY || !psync_r) begin
          has_follow = 1'b1; follow = EV_UNSELECTED;
        end
      end
      default: has_follow = 1'b0;
    endcase
  end

  assign last     = !ev_live || !has_follow || (hop_r == {HopW{1'b1}});
  assign out_free = !out_valid_r || out_ready;
  assign go       = (seq_r == S_RUN) && (!last || out_free);

  lmux_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (in_xfer),
    .ready_set (in_ready_set),
    .step_en   (go && ev_live),
    .ns        (ns),
    .uop       (uop),
    .cur       (cur),
    .nxt       (nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      hop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go && last) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (seq_r)
        S_IDLE: begin
          if (in_xfer) begin
            seq_r <= S_RUN;
            hop_r <= '0;
          end
        end
        S_RUN: begin
          if (go) begin
            if (last) begin
              seq_r <= S_IDLE;
            end else begin
              hop_r <= hop_r + 1'b1;
            end
          end
        end
        default: seq_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r    <= in_event_req;
      sel_r   <= in_selection;
      psync_r <= in_partner_sync;
    end else if (go && !last) begin
      ev_r <= follow;
    end
    if (go && last) res_r <= nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_mux_state_out      = res_r.pstate;
  assign out_actor_sync         = res_r.actor[BitSync];
  assign out_actor_collecting   = res_r.actor[BitColl];
  assign out_actor_distributing = res_r.actor[BitDist];
  assign out_need_to_transmit   = res_r.ntt;
  assign out_bond_member        = res_r.member;
  assign out_wait_start         = res_r.wstart;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("sequencer did not start after input transfer");

  a_detach_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (go && ev_live && ns == ST_DETACHED) |=> !cur.ready_flag)
    else $error("detached entry left ready flag set");

  a_member_only_colldist: assert property (@(posedge clk) disable iff (!rst_n)
    cur.member |-> cur.pstate == ST_COLLDIST)
    else $error("bond member outside the coll/dist state");

  a_dist_implies_sync: assert property (@(posedge clk) disable iff (!rst_n)
    cur.actor[BitDist] |-> (cur.actor[BitSync] && cur.actor[BitColl]))
    else $error("distributing without sync and collecting");

endmodule
